>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks sampled on clk, off while arst_n is low.
`define SHCB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`define SHCB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> design/shcb_pkg.sv
`default_nettype none

package shcb_pkg;

	localparam int unsigned TABLE_DEPTH_DEF   = 16384;
	localparam int unsigned MAX_RUN_DEF       = 64;
	localparam int unsigned SAMPLE_COUNT_DEF  = 24;
	localparam int unsigned TOKEN_BITS_DEF    = 16;
	localparam int unsigned POSITION_BITS_DEF = 24;

	localparam int unsigned MIN_RUN_W    = 7;
	localparam int unsigned TABLE_SIZE_W = 15;

	localparam logic [MIN_RUN_W-1:0]    MIN_RUN_RST    = 7'd24;
	localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RST = 15'd14051;

	// rotate-xor hash runs on a 31-bit word
	localparam int unsigned HASH_W = 31;

	localparam int unsigned PADDR_W     = 3;
	localparam int unsigned PDATA_W     = 32;
	localparam int unsigned REG_SEL_BIT = 2;

	localparam logic REG_MIN_RUN    = 1'b0;
	localparam logic REG_TABLE_SIZE = 1'b1;

endpackage

`default_nettype wire

>>> design/shcb_win_ram.sv
`default_nettype none

module shcb_win_ram #(
	parameter int unsigned ADDR_W = $clog2(shcb_pkg::MAX_RUN_DEF),
	parameter int unsigned DATA_W = shcb_pkg::TOKEN_BITS_DEF + 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/shcb_offsets.sv
`default_nettype none

module shcb_offsets #(
	parameter int unsigned MAX_RUN      = shcb_pkg::MAX_RUN_DEF,
	parameter int unsigned SAMPLE_COUNT = shcb_pkg::SAMPLE_COUNT_DEF
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    recalc,
	input  logic [$clog2(MAX_RUN+1)-1:0]                            run_len,
	input  logic [(SAMPLE_COUNT > 1 ? $clog2(SAMPLE_COUNT) : 1)-1:0] rd_idx,
	output logic [$clog2(MAX_RUN)-1:0]                              offset,
	output logic                                                    busy
);

	localparam int unsigned RNW        = $clog2(MAX_RUN + 1);
	localparam int unsigned OW         = $clog2(MAX_RUN);
	localparam int unsigned KW         = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam int unsigned DEN        = 2 * (SAMPLE_COUNT - 1);
	localparam int unsigned RW         = $clog2(DEN + 2 * (MAX_RUN - 1) + 1);
	localparam bit          ONE_SAMPLE = (SAMPLE_COUNT == 1);

	logic              busy_q;
	logic [KW-1:0]     k_q;
	logic [RW-1:0]     r_q;
	logic [OW-1:0]     off_q;
	logic [RW-1:0]     inc;
	logic              store;
	logic [OW-1:0]     offs_q [SAMPLE_COUNT];

	// offset n = floor((2n(m-1) + S-1) / 2(S-1)), walked by repeated subtraction
	assign inc   = RW'(run_len - RNW'(1)) << 1;
	assign store = busy_q && (ONE_SAMPLE || (r_q < RW'(DEN)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			k_q    <= '0;
			r_q    <= RW'(SAMPLE_COUNT - 1);
			off_q  <= '0;
		end else if (recalc) begin
			busy_q <= 1'b1;
			k_q    <= '0;
			r_q    <= RW'(SAMPLE_COUNT - 1);
			off_q  <= '0;
		end else if (busy_q) begin
			if (ONE_SAMPLE) begin
				busy_q <= 1'b0;
			end else if (r_q >= RW'(DEN)) begin
				r_q   <= r_q - RW'(DEN);
				off_q <= off_q + 1'b1;
			end else begin
				r_q <= r_q + inc;
				if (k_q == KW'(SAMPLE_COUNT - 1)) begin
					busy_q <= 1'b0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			offs_q[k_q] <= off_q;
		end
	end

	assign offset = offs_q[rd_idx];
	assign busy   = busy_q;

endmodule

`default_nettype wire

>>> design/shcb_mod.sv
`default_nettype none

module shcb_mod #(
	parameter int unsigned TABLE_DEPTH = shcb_pkg::TABLE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [shcb_pkg::HASH_W-1:0]        dividend,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]   divisor,
	output logic [$clog2(TABLE_DEPTH)-1:0]     rem,
	output logic                               done
);

	import shcb_pkg::*;

	localparam int unsigned MW  = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned TIW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW  = $clog2(HASH_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [HASH_W-1:0] dvd_q;
	logic [MW-1:0]     div_q;
	logic [MW-1:0]     rem_q;
	logic [MW:0]       trial;
	logic [MW:0]       diff;
	logic [MW-1:0]     rem_nx;

	// restoring remainder, one dividend bit per cycle
	assign trial  = {rem_q, dvd_q[HASH_W-1]};
	assign diff   = trial - {1'b0, div_q};
	assign rem_nx = (trial >= {1'b0, div_q}) ? diff[MW-1:0] : trial[MW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(HASH_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nx;
		end
	end

	assign rem  = rem_q[TIW-1:0];
	assign done = done_q;

endmodule

`default_nettype wire

>>> design/shcb_table.sv
`default_nettype none

module shcb_table #(
	parameter int unsigned DEPTH  = shcb_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned DATA_W = shcb_pkg::POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	output logic [DATA_W-1:0]        rd_data,
	output logic                     clearing
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic              clr_busy_q;
	logic [AW-1:0]     clr_q;
	logic [DATA_W-1:0] mem_q [DEPTH];

	// zero sweep after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

	assign clearing = clr_busy_q;

endmodule

`default_nettype wire

>>> design/sampled_hash_chain_builder.sv
// Flow: a token that completes no full run leaves the sequencer idle; one whose run start
// may not start a run is dropped after the flag check; a hashed token takes the flag check,
// one window memory read per sample, a bit-serial modulo, then table read and write.
// No new token is taken until the last is through; a waiting link holds only the table write.
// Reset: arst_n clears control state; the position table is then zeroed entry by entry
// and the sample offsets rebuilt, with token_stall high until both are done.
`default_nettype none

`include "assert_macros.svh"

module sampled_hash_chain_builder #(
	parameter int unsigned TABLE_DEPTH   = shcb_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned MAX_RUN       = shcb_pkg::MAX_RUN_DEF,
	parameter int unsigned SAMPLE_COUNT  = shcb_pkg::SAMPLE_COUNT_DEF,
	parameter int unsigned TOKEN_BITS    = shcb_pkg::TOKEN_BITS_DEF,
	parameter int unsigned POSITION_BITS = shcb_pkg::POSITION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          token_valid,
	output logic                          token_stall,
	input  logic [TOKEN_BITS-1:0]         token_value,
	input  logic                          may_start,
	input  logic                          end_of_text,
	output logic                          link_valid,
	input  logic                          link_stall,
	output logic [POSITION_BITS-1:0]      link_from,
	output logic [POSITION_BITS-1:0]      link_to,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [shcb_pkg::PADDR_W-1:0]  paddr,
	input  logic [shcb_pkg::PDATA_W-1:0]  pwdata,
	output logic [shcb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	import shcb_pkg::*;

	localparam int unsigned WA  = $clog2(MAX_RUN);
	localparam int unsigned RNW = $clog2(MAX_RUN + 1);
	localparam int unsigned KW  = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam int unsigned MW  = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned TIW = $clog2(TABLE_DEPTH);
	localparam int unsigned PB  = POSITION_BITS;
	localparam int unsigned PW1 = POSITION_BITS + 1;
	localparam int unsigned WD  = TOKEN_BITS + 1;

	typedef enum logic [8:0] {
		ST_INIT  = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_FLAG  = 9'b000000100,
		ST_FCHK  = 9'b000001000,
		ST_SAMP  = 9'b000010000,
		ST_HLAST = 9'b000100000,
		ST_MOD   = 9'b001000000,
		ST_TRD   = 9'b010000000,
		ST_TWR   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [MIN_RUN_W-1:0]    min_run_q;
	logic [TABLE_SIZE_W-1:0] table_size_q;
	logic                    cfg_wr;
	logic [RNW-1:0]          m_eff;
	logic [RNW-1:0]          m1;
	logic [MW-1:0]           mod_div;

	logic                    accept;
	logic [RNW-1:0]          tit_q;
	logic [RNW-1:0]          tit_inc;
	logic                    hashable;
	logic [WA-1:0]           wp_q;
	logic [WA-1:0]           base_q;
	logic [PB-1:0]           pos_q;
	logic [PB-1:0]           start_q;
	logic [PW1-1:0]          pos_w;
	logic [PW1-1:0]          back_w;
	logic [PW1-1:0]          start_w;

	logic [KW-1:0]           k_q;
	logic                    dv_s1;
	logic [HASH_W-1:0]       h_q;
	logic [HASH_W-1:0]       h_next;

	logic                    win_re;
	logic [WA-1:0]           win_raddr;
	logic [WD-1:0]           win_rdata;
	logic                    offs_busy;
	logic [WA-1:0]           offs_val;
	logic [WA-1:0]           off_lim;

	logic                    mod_start;
	logic                    mod_done;
	logic [TIW-1:0]          mod_rem;

	logic                    tbl_rd;
	logic                    tbl_wr;
	logic [PB-1:0]           tbl_rdata;
	logic                    tbl_clearing;

	logic                    out_free;
	logic                    out_load;
	logic                    link_valid_q;
	logic [PB-1:0]           link_from_q;
	logic [PB-1:0]           link_to_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_run_q    <= MIN_RUN_RST;
			table_size_q <= TABLE_SIZE_RST;
		end else if (cfg_wr) begin
			case (paddr[REG_SEL_BIT])
				REG_MIN_RUN:    min_run_q    <= pwdata[MIN_RUN_W-1:0];
				REG_TABLE_SIZE: table_size_q <= pwdata[TABLE_SIZE_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[REG_SEL_BIT])
			REG_MIN_RUN:    prdata = PDATA_W'(min_run_q);
			REG_TABLE_SIZE: prdata = PDATA_W'(table_size_q);
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		if (min_run_q == '0) begin
			m_eff = RNW'(1);
		end else if (32'(min_run_q) > MAX_RUN) begin
			m_eff = RNW'(MAX_RUN);
		end else begin
			m_eff = RNW'(min_run_q);
		end
	end

	always_comb begin
		if (table_size_q == '0) begin
			mod_div = MW'(1);
		end else if (32'(table_size_q) > TABLE_DEPTH) begin
			mod_div = MW'(TABLE_DEPTH);
		end else begin
			mod_div = MW'(table_size_q);
		end
	end

	assign m1 = m_eff - RNW'(1);

	// input side
	assign token_stall = (state_q != ST_IDLE) || offs_busy;
	assign accept      = token_valid && !token_stall;
	assign tit_inc     = (32'(tit_q) < MAX_RUN) ? tit_q + 1'b1 : tit_q;
	assign hashable    = tit_inc >= m_eff;

	// run start, wrapping over 1 .. 2^PB-1
	assign pos_w   = {1'b0, pos_q};
	assign back_w  = PW1'(m1);
	assign start_w = (pos_w > back_w) ? pos_w - back_w
	                                  : {1'b0, {PB{1'b1}}} - (back_w - pos_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tit_q <= '0;
			wp_q  <= '0;
			pos_q <= PB'(1);
		end else if (accept) begin
			tit_q <= end_of_text ? '0 : tit_inc;
			wp_q  <= wp_q + 1'b1;
			pos_q <= (pos_q == {PB{1'b1}}) ? PB'(1) : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_w[PB-1:0];
		end
		if (state_q == ST_FLAG) begin
			base_q <= wp_q - WA'(m_eff);
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (!tbl_clearing && !offs_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && hashable) begin
					state_d = ST_FLAG;
				end
			end
			ST_FLAG: state_d = ST_FCHK;
			ST_FCHK: begin
				state_d = win_rdata[TOKEN_BITS] ? ST_SAMP : ST_IDLE;
			end
			ST_SAMP: begin
				if (k_q == KW'(SAMPLE_COUNT - 1)) begin
					state_d = ST_HLAST;
				end
			end
			ST_HLAST: state_d = ST_MOD;
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_TRD;
				end
			end
			ST_TRD: state_d = ST_TWR;
			ST_TWR: begin
				if (tbl_wr) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			k_q     <= '0;
			dv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			dv_s1   <= (state_q == ST_SAMP);
			if (state_q == ST_SAMP) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
			end
		end
	end

	// sample fetch and hash
	assign off_lim   = (RNW'(offs_val) > m1) ? WA'(m1) : offs_val;
	assign win_re    = (state_q == ST_FLAG) || (state_q == ST_SAMP);
	assign win_raddr = (state_q == ST_FLAG) ? wp_q - WA'(m_eff) : base_q + off_lim;
	assign h_next    = {h_q[HASH_W-2:0], h_q[HASH_W-1]} ^ HASH_W'(win_rdata[TOKEN_BITS-1:0]);

	always_ff @(posedge clk) begin
		if (state_q == ST_FCHK) begin
			h_q <= '0;
		end else if (dv_s1) begin
			h_q <= h_next;
		end
	end

	assign mod_start = (state_q == ST_HLAST);

	// table update and link output
	assign tbl_rd   = (state_q == ST_TRD);
	assign out_free = !link_valid_q || !link_stall;
	assign out_load = (state_q == ST_TWR) && (tbl_rdata != '0) && out_free;
	assign tbl_wr   = (state_q == ST_TWR) && ((tbl_rdata == '0) || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_valid_q <= 1'b0;
		end else if (out_load) begin
			link_valid_q <= 1'b1;
		end else if (!link_stall) begin
			link_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			link_from_q <= tbl_rdata;
			link_to_q   <= start_q;
		end
	end

	assign link_valid = link_valid_q;
	assign link_from  = link_from_q;
	assign link_to    = link_to_q;

	shcb_win_ram #(
		.ADDR_W (WA),
		.DATA_W (WD)
	) u_win (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata ({may_start, token_value}),
		.re    (win_re),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	shcb_offsets #(
		.MAX_RUN      (MAX_RUN),
		.SAMPLE_COUNT (SAMPLE_COUNT)
	) u_offs (
		.clk     (clk),
		.arst_n  (arst_n),
		.recalc  (cfg_wr && (paddr[REG_SEL_BIT] == REG_MIN_RUN)),
		.run_len (m_eff),
		.rd_idx  (k_q),
		.offset  (offs_val),
		.busy    (offs_busy)
	);

	shcb_mod #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (h_next),
		.divisor  (mod_div),
		.rem      (mod_rem),
		.done     (mod_done)
	);

	shcb_table #(
		.DEPTH  (TABLE_DEPTH),
		.DATA_W (PB)
	) u_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (tbl_rd),
		.rd_addr  (mod_rem),
		.wr_en    (tbl_wr),
		.wr_addr  (mod_rem),
		.wr_data  (start_q),
		.rd_data  (tbl_rdata),
		.clearing (tbl_clearing)
	);

	`SHCB_ASSERT_IMP(a_link_nonzero, link_valid, (link_from != '0) && (link_to != '0), "link names an empty position")
	`SHCB_ASSERT_IMP(a_clear_stalls, tbl_clearing, token_stall, "token taken during table clear")
	`SHCB_ASSERT_IMP(a_mod_in_state, mod_done, state_q == ST_MOD, "modulo result outside wait state")
	`SHCB_ASSERT(a_pos_nonzero, pos_q != '0, "position counter reached zero")

endmodule

`default_nettype wire
